// ----- rtl/assert_macros.svh -----
// assertion macros used by q16_saturating_alu_core
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- rtl/q16sa_pkg.sv -----
// types and constants of the q16.16 saturating alu
// no dependencies
package q16sa_pkg;

	localparam int FRAC_BITS = 16;
	localparam int NUM_W = 32 + FRAC_BITS;
	localparam int DIV_STEPS = NUM_W;

	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_MUL = 2'd0;
	localparam cmd_t CMD_DIV = 2'd1;
	localparam cmd_t CMD_CLAMP = 2'd2;
	localparam cmd_t CMD_ABS = 2'd3;

	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = -32'sh7FFF_FFFF - 32'sd1;

	// one beat as it travels down the divider chain
	typedef struct packed {
		logic              valid;
		logic              is_div;
		logic              neg;
		logic [31:0]       rem;
		logic [NUM_W-1:0]  num;
		logic [31:0]       den;
		logic signed [31:0] byp;
	} cell_t;

endpackage

// ----- rtl/q16sa_front.sv -----
// input stage: multiplier, clamp, abs and divider setup
// depends on q16sa_pkg
module q16sa_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  q16sa_pkg::cmd_t    cmd,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	input  logic signed [31:0] operand_c,
	output q16sa_pkg::cell_t   head
);
	import q16sa_pkg::*;

	logic                     valid_s1;
	cmd_t                     cmd_s1;
	logic signed [63:0]       prod_s1;
	logic signed [31:0]       byp_s1;
	logic                     div_en_s1;
	logic [NUM_W-1:0]         num_s1;
	logic [31:0]              den_s1;
	logic                     neg_s1;

	logic signed [31:0] byp_in;
	logic [31:0]        abs_a;
	logic [31:0]        abs_b;
	logic signed [NUM_W-1:0] shifted;
	logic signed [31:0] mul_sat;

	// magnitudes as unsigned, most negative maps to 2^31
	assign abs_a = operand_a[31] ? (32'd0 - operand_a) : operand_a;
	assign abs_b = operand_b[31] ? (32'd0 - operand_b) : operand_b;

	// results that need no divider
	always_comb begin
		unique case (cmd)
			CMD_CLAMP: begin
				if (operand_a < operand_b) byp_in = operand_b;
				else if (operand_a > operand_c) byp_in = operand_c;
				else byp_in = operand_a;
			end
			CMD_ABS: byp_in = operand_a[31] ? (abs_a[31] ? Q_MAX : $signed(abs_a)) : operand_a;
			CMD_DIV: byp_in = operand_a[31] ? Q_MIN : Q_MAX;
			default: byp_in = operand_a;
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else valid_s1 <= accept;
	end

	// payload
	always_ff @(posedge clk) begin
		cmd_s1 <= cmd;
		prod_s1 <= operand_a * operand_b;
		byp_s1 <= byp_in;
		div_en_s1 <= (cmd == CMD_DIV) && (operand_b != 32'sd0);
		num_s1 <= {abs_a, {FRAC_BITS{1'b0}}};
		den_s1 <= abs_b;
		neg_s1 <= operand_a[31] ^ operand_b[31];
	end

	// multiply: floor shift then saturate
	assign shifted = prod_s1[63:FRAC_BITS];
	always_comb begin
		if (shifted[NUM_W-1:31] == {(NUM_W-31){1'b0}} ||
			shifted[NUM_W-1:31] == {(NUM_W-31){1'b1}})
			mul_sat = shifted[31:0];
		else
			mul_sat = shifted[NUM_W-1] ? Q_MIN : Q_MAX;
	end

	always_comb begin
		head.valid = valid_s1;
		head.is_div = div_en_s1;
		head.neg = neg_s1;
		head.rem = 32'd0;
		head.num = num_s1;
		head.den = den_s1;
		head.byp = (cmd_s1 == CMD_MUL) ? mul_sat : byp_s1;
	end

endmodule

// ----- rtl/q16sa_div_cell.sv -----
// one restoring division step: one quotient bit per cell
// depends on q16sa_pkg
module q16sa_div_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  q16sa_pkg::cell_t d,
	output q16sa_pkg::cell_t q
);
	import q16sa_pkg::*;

	logic        valid_q;
	cell_t       pay_q;
	cell_t       pay_d;
	logic [32:0] trial;
	logic [32:0] diff;
	logic        qbit;

	// shift in next dividend bit and try to subtract
	assign trial = {d.rem, d.num[NUM_W-1]};
	assign diff = trial - {1'b0, d.den};
	assign qbit = !diff[32];

	// next payload: partial remainder and quotient bit shifted in
	always_comb begin
		pay_d = d;
		pay_d.rem = qbit ? diff[31:0] : trial[31:0];
		pay_d.num = {d.num[NUM_W-2:0], qbit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else valid_q <= d.valid;
	end

	always_ff @(posedge clk) begin
		pay_q <= pay_d;
	end

	always_comb begin
		q = pay_q;
		q.valid = valid_q;
	end

endmodule

// ----- rtl/q16sa_back.sv -----
// output stage: sign and saturation of the quotient, result register
// depends on q16sa_pkg
module q16sa_back (
	input  logic               clk,
	input  logic               arst_n,
	input  q16sa_pkg::cell_t   tail,
	output logic               done,
	output logic signed [31:0] result
);
	import q16sa_pkg::*;

	logic               done_q;
	logic signed [31:0] result_q;
	logic signed [31:0] res_d;
	logic               big;

	// quotient magnitude beyond 32 bits
	assign big = tail.num[NUM_W-1:32] != {(NUM_W-32){1'b0}};

	always_comb begin
		if (!tail.is_div) res_d = tail.byp;
		else if (tail.neg) begin
			if (big || (tail.num[31] && tail.num[30:0] != 31'd0)) res_d = Q_MIN;
			else res_d = $signed(32'd0 - tail.num[31:0]);
		end else begin
			if (big || tail.num[31]) res_d = Q_MAX;
			else res_d = $signed(tail.num[31:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= tail.valid;
	end

	always_ff @(posedge clk) begin
		result_q <= res_d;
	end

	assign done = done_q;
	assign result = result_q;

endmodule

// ----- rtl/q16_saturating_alu_core.sv -----
// q16.16 saturating alu: multiply, divide, clamp, absolute value
// depends on q16sa_pkg, q16sa_front, q16sa_div_cell, q16sa_back, assert_macros.svh
//
// usage: drive cmd and operand_a/b/c and raise start; a beat is taken at
// every rising edge with start high and busy low. busy stays low, so one
// beat can enter every cycle.
// each beat yields one result on result, marked by done for one cycle,
// in order of entry.
// path: one input stage (multiplier and operand setup), 48 divider
// cells (one quotient bit each), one output register. every command
// takes the same path so ordering is kept.
// throughput: one beat per cycle.
// reset: arst_n clears all valid flags; beats in flight are dropped.
// the receiver cannot stall: done is a strobe and must be taken.
module q16_saturating_alu_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  q16sa_pkg::cmd_t    cmd,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	input  logic signed [31:0] operand_c,
	output logic               done,
	output logic signed [31:0] result
);
	import q16sa_pkg::*;
	`include "assert_macros.svh"

	localparam int LAT = DIV_STEPS + 2;

	cell_t link [0:DIV_STEPS];
	logic  accept;

	assign busy = 1'b0;
	assign accept = start && !busy;

	q16sa_front u_front (
		.clk(clk), .arst_n(arst_n), .accept(accept), .cmd(cmd),
		.operand_a(operand_a), .operand_b(operand_b), .operand_c(operand_c),
		.head(link[0])
	);

	// divider chain
	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
		q16sa_div_cell u_cell (
			.clk(clk), .arst_n(arst_n), .d(link[i]), .q(link[i+1])
		);
	end

	q16sa_back u_back (
		.clk(clk), .arst_n(arst_n), .tail(link[DIV_STEPS]),
		.done(done), .result(result)
	);

	`ASSERT_IMPL(beat_latency_a, accept, ##LAT done)
	`ASSERT_IMPL(abs_nonneg_a, accept && cmd == CMD_ABS, ##LAT !result[31])
	`ASSERT_NEXT(never_busy_a, 1'b1, !busy)

endmodule
